// File: hw/rtl/pbmm_pkg.sv
// Shared types and constants for the pattern bank majority match core.
// No dependencies.
package pbmm_pkg;

    typedef enum logic [2:0] {
        CMD_CLEAR_BANK = 3'd0,
        CMD_STAGE      = 3'd1,
        CMD_PUSH       = 3'd2,
        CMD_CLEAR_HITS = 3'd3,
        CMD_MARK_HIT   = 3'd4,
        CMD_LOOKUP     = 3'd5,
        CMD_RETRIEVE   = 3'd6,
        CMD_NONE       = 3'd7
    } t_cmd;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [0:0] REG_LAYERS = 1'b0;
    localparam logic [0:0] REG_MISSES = 1'b1;

    localparam int HIT_WORDS = 1024;

    // Queue entry between front and back parts.
    typedef struct packed {
        t_cmd        cmd;
        logic [2:0]  layer;
        logic [15:0] superstrip;
        logic [15:0] inv_pt;
        logic [31:0] frequency;
        logic [11:0] index;
    } t_item;

endpackage

// File: hw/rtl/pbmm_front.sv
// Front part: accepts items, drops CMD_NONE items, and queues the rest.
// Depends on pbmm_pkg.
module pbmm_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  pbmm_pkg::t_item i_item,
    output logic           o_q_valid,
    input  logic           i_q_pop,
    output pbmm_pkg::t_item o_q_item
);
    import pbmm_pkg::*;

    t_item       r_q [2];
    logic [1:0]  r_cnt;
    logic        r_wr;
    logic        r_rd;
    logic        push;

    assign o_stall   = (r_cnt == 2'd2);
    assign push      = i_valid && !o_stall && (i_item.cmd != CMD_NONE);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= i_item;
        end
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
        end else begin
            if (push) r_wr <= !r_wr;
            if (i_q_pop) r_rd <= !r_rd;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end
endmodule

// File: hw/rtl/pbmm_back.sv
// Back part: bank memories, hit map, staging register, command sequencer.
// Depends on pbmm_pkg.
module pbmm_back #(
    parameter int PATTERN_LAYERS = 8,
    parameter int BANK_DEPTH     = 4096,
    parameter int LOOKUP_BLOCK   = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    output logic            o_q_pop,
    input  pbmm_pkg::t_item i_item,
    input  logic [3:0]      i_layers_in_use,
    input  logic [3:0]      i_max_misses,
    output logic            o_busy,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [11:0]     o_pattern_index,
    output logic            o_found,
    output logic [15:0]     o_superstrip_out,
    output logic [15:0]     o_inv_pt_out,
    output logic [31:0]     o_frequency_out,
    output logic [1:0]      o_status,
    output logic            o_last
);
    import pbmm_pkg::*;

    localparam int LW = (PATTERN_LAYERS > 1) ? $clog2(PATTERN_LAYERS) : 1;
    localparam int BW = $clog2(BANK_DEPTH);
    localparam int CW = BW + 1;
    localparam int PW = (CW > 19) ? CW : 19;
    localparam int JW = $clog2(LOOKUP_BLOCK) + 1;
    localparam int SW = (BW + LW > 0) ? BW + LW : 1;
    localparam logic [LW:0] NLAY = (LW + 1)'(PATTERN_LAYERS);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_HCLR  = 6'b000010,
        S_LREAD = 6'b000100,
        S_LEVAL = 6'b001000,
        S_RREAD = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state;
    logic [15:0] r_ss_mem [BANK_DEPTH * (1 << LW)];
    logic [15:0] r_ipt_mem [BANK_DEPTH];
    logic [31:0] r_frq_mem [BANK_DEPTH];
    logic [63:0] r_hit_mem [HIT_WORDS];
    logic [15:0] r_stage [PATTERN_LAYERS];
    logic [CW-1:0] r_count;
    t_item r_cur;
    logic [PW-1:0] r_pat;       // current pattern
    logic [LW:0] r_lay;         // layer counter
    logic [LW:0] r_nl;
    logic [4:0]  r_miss;
    logic [JW-1:0] r_j;
    logic        r_any;
    logic [11:0] r_fire_idx;    // fired pattern held back until the next one or the end
    logic [9:0]  r_hclr;
    logic        r_rd_pend;
    logic [15:0] r_ss_rd;
    logic [63:0] r_hit_rd;
    logic [15:0] r_ipt_rd;
    logic [31:0] r_frq_rd;
    logic        r_hw_pend;
    logic [15:0] r_hw_ss;
    logic        r_hit_vld; // hit word read valid
    logic [15:0] r_hit_ss;
    // output register
    logic        r_ov;
    logic [11:0] r_o_idx;
    logic        r_o_found;
    logic [15:0] r_o_ss;
    logic [15:0] r_o_ipt;
    logic [31:0] r_o_frq;
    logic [1:0]  r_o_st;
    logic        r_o_last;

    logic out_free;
    logic [SW-1:0] ss_addr;
    logic [BW-1:0] pat_addr;
    logic [LW:0] nl_sat;

    assign out_free = !r_ov || !i_stall;
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid && out_free && !r_hw_pend && !r_rd_pend;
    assign o_busy   = (r_state != S_IDLE) || r_hw_pend || r_rd_pend;
    assign nl_sat   = (int'(i_layers_in_use) > PATTERN_LAYERS) ? NLAY
                                                               : (LW + 1)'(i_layers_in_use);
    assign pat_addr = r_pat[BW-1:0];
    assign ss_addr  = SW'({pat_addr, r_lay[LW-1:0]});

    assign o_valid          = r_ov;
    assign o_pattern_index  = r_o_idx;
    assign o_found          = r_o_found;
    assign o_superstrip_out = r_o_ss;
    assign o_inv_pt_out     = r_o_ipt;
    assign o_frequency_out  = r_o_frq;
    assign o_status         = r_o_st;
    assign o_last           = r_o_last;

    // Memory ports
    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_item.cmd == CMD_PUSH && r_count < CW'(BANK_DEPTH)) begin
            r_ipt_mem[r_count[BW-1:0]] <= i_item.inv_pt;
            r_frq_mem[r_count[BW-1:0]] <= i_item.frequency;
        end
        r_ss_rd  <= r_ss_mem[ss_addr];
        r_ipt_rd <= r_ipt_mem[pat_addr];
        r_frq_rd <= r_frq_mem[pat_addr];
    end

    // Superstrip layers of a push are written one per cycle in S_IDLE while r_rd_pend is set
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && r_rd_pend) begin
            r_ss_mem[ss_addr] <= r_stage[r_lay[LW-1:0]];
        end
    end

    // Hit map: read-modify-write for mark, sweep for clear, read for lookup
    always_ff @(posedge i_clk) begin
        r_hit_rd <= r_hit_mem[r_hw_pend ? r_hw_ss[15:6] : r_ss_rd[15:6]];
        if (r_state == S_HCLR) begin
            r_hit_mem[r_hclr] <= 64'd0;
        end else if (r_hit_vld) begin
            r_hit_mem[r_hit_ss[15:6]] <= r_hit_rd | (64'd1 << r_hit_ss[5:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_HCLR;
            r_hclr    <= 10'd0;
            r_count   <= '0;
            r_ov      <= 1'b0;
            r_rd_pend <= 1'b0;
            r_hw_pend <= 1'b0;
            r_hit_vld <= 1'b0;
            for (int i = 0; i < PATTERN_LAYERS; i++) r_stage[i] <= 16'd0;
        end else begin
            if (r_ov && !i_stall) r_ov <= 1'b0;
            r_hit_vld <= r_hw_pend;
            if (r_hw_pend) begin
                r_hit_ss  <= r_hw_ss;
                r_hw_pend <= 1'b0;
            end
            unique case (r_state)
                S_HCLR: begin
                    r_hclr <= r_hclr + 10'd1;
                    if (r_hclr == 10'(HIT_WORDS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (r_rd_pend) begin
                        // write staged layers of a push
                        r_lay <= r_lay + 1'b1;
                        if (r_lay == NLAY - 1'b1) r_rd_pend <= 1'b0;
                    end else if (o_q_pop) begin
                        r_cur <= i_item;
                        r_pat <= '0;
                        r_lay <= '0;
                        unique case (i_item.cmd)
                            CMD_CLEAR_BANK: r_count <= '0;
                            CMD_STAGE: begin
                                if (int'(i_item.layer) < PATTERN_LAYERS)
                                    r_stage[LW'(i_item.layer)] <= i_item.superstrip;
                            end
                            CMD_PUSH: begin
                                r_ov <= 1'b1; r_o_found <= 1'b0; r_o_ss <= '0;
                                r_o_ipt <= '0; r_o_frq <= '0; r_o_last <= 1'b1;
                                if (r_count < CW'(BANK_DEPTH)) begin
                                    r_o_idx   <= 12'(r_count);
                                    r_o_st    <= ST_OK;
                                    r_pat     <= PW'(r_count);
                                    r_count   <= r_count + 1'b1;
                                    r_rd_pend <= 1'b1;
                                end else begin
                                    r_o_idx <= '0;
                                    r_o_st  <= ST_FULL;
                                end
                            end
                            CMD_CLEAR_HITS: begin
                                r_hclr  <= '0;
                                r_state <= S_HCLR;
                            end
                            CMD_MARK_HIT: begin
                                r_hw_pend <= 1'b1;
                                r_hw_ss   <= i_item.superstrip;
                            end
                            CMD_LOOKUP: begin
                                r_pat   <= PW'(i_item.index) * PW'(LOOKUP_BLOCK);
                                r_j     <= '0;
                                r_any   <= 1'b0;
                                r_miss  <= '0;
                                r_nl    <= nl_sat;
                                r_state <= S_LREAD;
                            end
                            CMD_RETRIEVE: begin
                                if ({1'b0, i_item.index} >= r_count) begin
                                    r_ov <= 1'b1; r_o_idx <= i_item.index;
                                    r_o_found <= 1'b0; r_o_ss <= '0; r_o_ipt <= '0;
                                    r_o_frq <= '0; r_o_st <= ST_RANGE; r_o_last <= 1'b1;
                                end else begin
                                    r_pat   <= PW'(i_item.index);
                                    r_state <= S_RREAD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_LREAD: begin
                    // ss read issued for (r_pat, r_lay); hit word follows
                    if (r_j == JW'(LOOKUP_BLOCK) || r_pat >= PW'(r_count)) begin
                        if (out_free) begin
                            // send the held hit as the final one, or a not-found result
                            r_ov <= 1'b1; r_o_found <= r_any;
                            r_o_idx <= r_any ? r_fire_idx : 12'd0;
                            r_o_ss <= '0; r_o_ipt <= '0; r_o_frq <= '0;
                            r_o_st <= ST_OK; r_o_last <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end else if (r_lay == r_nl) begin
                        if (r_miss > {1'b0, i_max_misses}) begin
                            r_pat <= r_pat + 1'b1; r_j <= r_j + 1'b1;
                            r_lay <= '0; r_miss <= '0;
                        end else if (!r_any || out_free) begin
                            // flush the previous hit, keep this one pending
                            if (r_any) begin
                                r_ov <= 1'b1; r_o_idx <= r_fire_idx; r_o_found <= 1'b1;
                                r_o_ss <= '0; r_o_ipt <= '0; r_o_frq <= '0;
                                r_o_st <= ST_OK; r_o_last <= 1'b0;
                            end
                            r_any <= 1'b1; r_fire_idx <= 12'(r_pat);
                            r_pat <= r_pat + 1'b1; r_j <= r_j + 1'b1;
                            r_lay <= '0; r_miss <= '0;
                        end
                    end else begin
                        r_state <= S_LEVAL;
                    end
                end
                S_LEVAL: begin
                    // r_ss_rd valid now; hit word read next cycle
                    r_hit_ss <= r_ss_rd;
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (r_cur.cmd == CMD_LOOKUP) begin
                        if (!r_hit_rd[r_hit_ss[5:0]]) r_miss <= r_miss + 1'b1;
                        r_lay   <= r_lay + 1'b1;
                        r_state <= S_LREAD;
                    end else if (out_free) begin
                        r_ov <= 1'b1; r_o_idx <= r_cur.index; r_o_found <= 1'b0;
                        r_o_ss <= r_ss_rd; r_o_ipt <= r_ipt_rd; r_o_frq <= r_frq_rd;
                        r_o_st <= ST_OK; r_o_last <= (r_lay == NLAY - 1'b1);
                        r_lay  <= r_lay + 1'b1;
                        r_state <= (r_lay == NLAY - 1'b1) ? S_IDLE : S_RREAD;
                    end
                end
                S_RREAD: r_state <= S_OUT;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: hw/rtl/pattern_bank_majority_match_core.sv
// Pattern bank with majority-logic matching.
// Usage:
//   Input channel i_valid/o_stall carries one command per transfer; output
//   channel o_valid/i_stall returns result items, o_last on the final one.
//   Stage and clear bank complete when popped; mark hit does a read-modify-write
//   of the hit map. Push returns its result, then writes the stored layers one
//   per cycle. Lookup steps through S_LREAD, S_LEVAL and S_OUT for each compared
//   layer of each of up to 64 patterns, set by the single superstrip memory port
//   and the hit map read that follows it; retrieve gives one result per stored
//   layer, through S_RREAD then S_OUT. Clear hits sweeps the 1024-word hit map,
//   one word a cycle. After reset the hit map is swept the same way before
//   items are taken; bank count and staging layers are zeroed.
//   A stalled output holds its result and the sequencer waits; a two-entry
//   queue keeps accepting commands until it fills.
//   Configuration over APB: layers_in_use at 0x0, max_misses at 0x4,
//   to be written only while idle; the block itself does not enforce this.
// Depends on pbmm_pkg, pbmm_front and pbmm_back.
module pattern_bank_majority_match_core #(
    parameter int PATTERN_LAYERS = 8,
    parameter int BANK_DEPTH     = 4096,
    parameter int LOOKUP_BLOCK   = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_command,
    input  logic [2:0]  i_layer,
    input  logic [15:0] i_superstrip,
    input  logic signed [15:0] i_inv_pt,
    input  logic [31:0] i_frequency,
    input  logic [11:0] i_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [11:0] o_pattern_index,
    output logic        o_found,
    output logic [15:0] o_superstrip_out,
    output logic signed [15:0] o_inv_pt_out,
    output logic [31:0] o_frequency_out,
    output logic [1:0]  o_status,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pbmm_pkg::*;

    t_item in_item;
    t_item q_item;
    logic  q_valid;
    logic  q_pop;
    logic  busy;
    logic [15:0] ipt_raw;
    logic [3:0] r_layers;
    logic [3:0] r_misses;

    assign in_item = '{cmd: t_cmd'(i_command), layer: i_layer, superstrip: i_superstrip,
                       inv_pt: i_inv_pt, frequency: i_frequency, index: i_index};
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MISSES) ? {28'd0, r_misses} : {28'd0, r_layers};
    assign o_inv_pt_out = ipt_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layers <= 4'd8;
            r_misses <= 4'd0;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_LAYERS) r_layers <= pwdata[3:0];
            else                        r_misses <= pwdata[3:0];
        end
    end

    pbmm_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_item(in_item),
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_item(q_item)
    );

    pbmm_back #(
        .PATTERN_LAYERS(PATTERN_LAYERS), .BANK_DEPTH(BANK_DEPTH),
        .LOOKUP_BLOCK(LOOKUP_BLOCK)
    ) u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .o_q_pop(q_pop), .i_item(q_item),
        .i_layers_in_use(r_layers), .i_max_misses(r_misses), .o_busy(busy),
        .o_valid, .i_stall, .o_pattern_index, .o_found, .o_superstrip_out,
        .o_inv_pt_out(ipt_raw), .o_frequency_out, .o_status, .o_last
    );

    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");
    a_pop_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !busy)
        else $error("pop while busy");
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> o_status == ST_OK) else $error("found with status");
endmodule

// File: tb/testbench.sv
// Testbench for pattern_bank_majority_match_core: directed and random command streams,
// checked against an in-bench model of the pattern bank and hit map.
// Depends on pbmm_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;
    import pbmm_pkg::*;

    localparam int LAYERS = 8;
    localparam int DEPTH  = 4096;
    localparam int BLOCK  = 64;

    typedef struct packed {
        logic [11:0] pattern_index;
        logic        found;
        logic [15:0] superstrip;
        logic [15:0] inv_pt;
        logic [31:0] frequency;
        logic [1:0]  status;
        logic        last;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [2:0]  i_command = '0;
    logic [2:0]  i_layer = '0;
    logic [15:0] i_superstrip = '0;
    logic signed [15:0] i_inv_pt = '0;
    logic [31:0] i_frequency = '0;
    logic [11:0] i_index = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [11:0] o_pattern_index;
    logic        o_found;
    logic [15:0] o_superstrip_out;
    logic signed [15:0] o_inv_pt_out;
    logic [31:0] o_frequency_out;
    logic [1:0]  o_status;
    logic        o_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    pattern_bank_majority_match_core i_dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Bench copy of the block state
    logic [15:0] bank_ss [DEPTH*LAYERS];
    logic [15:0] bank_ipt [DEPTH];
    logic [31:0] bank_freq [DEPTH];
    int unsigned stored;
    logic [15:0] staging [LAYERS];
    bit          hits [65536];
    int unsigned cfg_layers = 8;
    int unsigned cfg_misses = 0;

    t_result     expected_results [$];
    int          errors = 0;
    int          send_gap_pct = 0;
    int          stall_pct = 0;
    bit          hold_receiver = 1'b0;

    function automatic t_result mk(int idx, bit fnd, logic [15:0] ss, logic [15:0] ipt,
                                   logic [31:0] fq, logic [1:0] st, bit lst);
        t_result r;
        r.pattern_index = idx[11:0];
        r.found = fnd;
        r.superstrip = ss;
        r.inv_pt = ipt;
        r.frequency = fq;
        r.status = st;
        r.last = lst;
        return r;
    endfunction

    function automatic void add_expected(t_result r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    task automatic predict_command(t_cmd cmd, logic [2:0] lyr, logic [15:0] ss,
                                   logic [15:0] ipt, logic [31:0] fq, logic [11:0] idx);
        int nl;
        int misses;
        int p;
        int n;
        n = 0;
        case (cmd)
            CMD_CLEAR_BANK: stored = 0;
            CMD_STAGE: staging[lyr] = ss;
            CMD_PUSH: begin
                if (stored < DEPTH) begin
                    for (int k = 0; k < LAYERS; k++) bank_ss[stored*LAYERS+k] = staging[k];
                    bank_ipt[stored] = ipt;
                    bank_freq[stored] = fq;
                    add_expected(mk(stored, 0, 0, 0, 0, ST_OK, 1));
                    stored++;
                end else begin
                    add_expected(mk(0, 0, 0, 0, 0, ST_FULL, 1));
                end
            end
            CMD_CLEAR_HITS: for (int h = 0; h < 65536; h++) hits[h] = 1'b0;
            CMD_MARK_HIT: hits[ss] = 1'b1;
            CMD_LOOKUP: begin
                nl = (cfg_layers > LAYERS) ? LAYERS : cfg_layers;
                for (int j = 0; j < BLOCK; j++) begin
                    p = int'(idx) * BLOCK + j;
                    if (p >= stored) break;
                    misses = 0;
                    for (int l = 0; l < nl; l++)
                        if (!hits[bank_ss[p*LAYERS+l]]) misses++;
                    if (misses <= cfg_misses) begin
                        add_expected(mk(p, 1, 0, 0, 0, ST_OK, 0));
                        n++;
                    end
                end
                if (n == 0) add_expected(mk(0, 0, 0, 0, 0, ST_OK, 1));
                else expected_results[$].last = 1'b1;
            end
            CMD_RETRIEVE: begin
                if (idx >= stored) begin
                    add_expected(mk(idx, 0, 0, 0, 0, ST_RANGE, 1));
                end else begin
                    for (int k = 0; k < LAYERS; k++)
                        add_expected(mk(idx, 0, bank_ss[idx*LAYERS+k],
                            bank_ipt[idx], bank_freq[idx], ST_OK, k == LAYERS - 1));
                end
            end
            default: ;
        endcase
    endtask

    // Send one command; the valid stays up between back-to-back transfers.
    task automatic send_command(t_cmd cmd, logic [2:0] lyr = '0, logic [15:0] ss = '0,
                                logic [15:0] ipt = '0, logic [31:0] fq = '0,
                                logic [11:0] idx = '0);
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_command    <= cmd;
        i_layer      <= lyr;
        i_superstrip <= ss;
        i_inv_pt     <= ipt;
        i_frequency  <= fq;
        i_index      <= idx;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_command(cmd, lyr, ss, ipt, fq, idx);
    endtask

    task automatic go_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        go_idle();
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (3000) @(posedge i_clk);
    endtask

    task automatic write_register(int reg_idx, int value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= 3'(reg_idx * 4);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_LAYERS) cfg_layers = value;
        else cfg_misses = value;
    endtask

    task automatic stage_pattern(logic [15:0] ss [LAYERS]);
        for (int k = 0; k < LAYERS; k++) send_command(CMD_STAGE, 3'(k), ss[k]);
    endtask

    // Receiver: random stalls plus an optional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b0;
        else i_stall <= hold_receiver || ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_pattern_index, o_found, o_superstrip_out, o_inv_pt_out,
                   o_frequency_out, o_status, o_last};
            if (expected_results.size() == 0) begin
                $error("unexpected result index=%0d", o_pattern_index);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (got.pattern_index !== want.pattern_index) begin
                    $error("pattern_index exp %0d got %0d", want.pattern_index,
                           got.pattern_index);
                    errors++;
                end
                if (got.found !== want.found) begin
                    $error("found exp %0d got %0d", want.found, got.found);
                    errors++;
                end
                if (got.superstrip !== want.superstrip) begin
                    $error("superstrip_out exp %h got %h", want.superstrip, got.superstrip);
                    errors++;
                end
                if (got.inv_pt !== want.inv_pt) begin
                    $error("inv_pt_out exp %h got %h", want.inv_pt, got.inv_pt);
                    errors++;
                end
                if (got.frequency !== want.frequency) begin
                    $error("frequency_out exp %h got %h", want.frequency, got.frequency);
                    errors++;
                end
                if (got.status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, got.status);
                    errors++;
                end
                if (got.last !== want.last) begin
                    $error("last exp %0d got %0d", want.last, got.last);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed();
        logic [15:0] ss [LAYERS];
        send_command(CMD_LOOKUP);                     // empty bank
        send_command(CMD_RETRIEVE, 0, 0, 0, 0, 12'hFFF);
        for (int k = 0; k < LAYERS; k++) ss[k] = (k == 0) ? 16'hFFFF : 16'(k);
        stage_pattern(ss);
        send_command(CMD_STAGE, 3'd7, 16'h0000);
        send_command(CMD_PUSH, 0, 0, 16'h8000, 32'hFFFF_FFFF);
        send_command(CMD_PUSH, 0, 0, 16'h7FFF, 32'h0);
        for (int k = 0; k < LAYERS; k++) send_command(CMD_MARK_HIT, 0, ss[k]);
        send_command(CMD_LOOKUP, 0, 0, 0, 0, 0);
        send_command(CMD_LOOKUP, 0, 0, 0, 0, 12'hFFF); // block beyond the bank
        send_command(CMD_RETRIEVE, 0, 0, 0, 0, 1);
        send_command(CMD_NONE, 3'h7, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 12'hFFF);
        send_command(CMD_CLEAR_HITS);
        send_command(CMD_LOOKUP);
        send_command(CMD_CLEAR_BANK);
        send_command(CMD_RETRIEVE, 0, 0, 0, 0, 0);
        drain();
    endtask

    // Well-formed build/mark/lookup sequences with random content and some noise
    task automatic test_random(int n_items);
        logic [15:0] ss [LAYERS];
        int sent;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(9))
                0, 1, 2: begin
                    for (int k = 0; k < LAYERS; k++) ss[k] = 16'($urandom_range(31)) << 11;
                    stage_pattern(ss);
                    send_command(CMD_PUSH, 0, 0, 16'($urandom), $urandom);
                    sent += 9;
                end
                3, 4: begin
                    send_command(CMD_MARK_HIT, 0, 16'($urandom_range(31)) << 11);
                    sent++;
                end
                5, 6: begin
                    send_command(CMD_LOOKUP, 0, 0, 0, 0, 12'($urandom_range(1)));
                    sent++;
                end
                7: begin
                    send_command(CMD_RETRIEVE, 0, 0, 0, 0,
                                 ($urandom_range(3) == 0) ? 12'($urandom) :
                                 12'($urandom_range(stored + 1)));
                    sent++;
                end
                8: begin
                    send_command(CMD_STAGE, 3'($urandom), 16'($urandom));
                    sent++;
                end
                default: begin
                    if ($urandom_range(3) == 0) send_command(CMD_CLEAR_HITS);
                    else if ($urandom_range(3) == 0) send_command(CMD_CLEAR_BANK);
                    else send_command(CMD_NONE, 3'($urandom), 16'($urandom));
                    sent++;
                end
            endcase
        end
        drain();
    endtask

    task automatic test_backpressure();
        int hold_cycles;
        fork
            begin
                hold_receiver = 1'b1;
                hold_cycles = 0;
                while (hold_cycles < 400) begin
                    @(posedge i_clk);
                    hold_cycles++;
                end
                hold_receiver = 1'b0;
            end
            for (int k = 0; k < 8; k++) send_command(CMD_RETRIEVE, 0, 0, 0, 0, 12'(k));
        join
        drain();
    endtask

    initial begin
        for (int h = 0; h < 65536; h++) hits[h] = 1'b0;
        for (int k = 0; k < LAYERS; k++) staging[k] = '0;
        stored = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_gap_pct = 23;
        stall_pct = 73;
        test_directed();
        write_register(REG_LAYERS, 0);
        write_register(REG_MISSES, 8);
        send_command(CMD_PUSH, 0, 0, 0, 32'h1);
        send_command(CMD_LOOKUP);
        drain();
        write_register(REG_LAYERS, 15);
        write_register(REG_MISSES, 0);
        send_command(CMD_LOOKUP);
        drain();
        write_register(REG_LAYERS, 4);
        write_register(REG_MISSES, 1);
        test_random(40);
        test_backpressure();
        send_gap_pct = 73;
        stall_pct = 23;
        write_register(REG_LAYERS, 8);
        write_register(REG_MISSES, 2);
        test_random(40);
        send_gap_pct = 0;
        stall_pct = 0;
        write_register(REG_LAYERS, 1);
        write_register(REG_MISSES, 0);
        test_random(40);
        if (errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
